[rtl/gcd_pkg.sv]
// ---------------------------------------------------------------------------
// gcd_pkg: shared types and constants for the great-circle distance block
// angle limits, fixed-point formats, cordic arctangent table and scale factors
// ---------------------------------------------------------------------------
package gcd_pkg;

  // field widths
  localparam int LAT_W      = 24;
  localparam int LON_W      = 25;
  localparam int DIST_W     = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_LAT = 2'd0,
    REG_REF_LON = 2'd1
  } cfg_reg_t;

  // q30 magnitude in [0, 1]
  typedef logic [30:0] q30_t;

  // clamp limits, degrees * 65536
  localparam logic signed [26:0] LAT_LIMIT = 27'sd5898240;
  localparam logic signed [26:0] LON_LIMIT = 27'sd11796480;

  // binary angle conversion: m * 2^k / 23592960 via m / 45
  localparam int           DegUnit     = 45;
  localparam logic [25:0]  RECIP_45    = 26'd47721858;
  localparam int           RECIP_SHIFT = 31;

  // cordic
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [61:0]        HALF_Q30 = 62'd536870912;
  localparam logic [62:0]        ONE_Q60  = 63'd1 << 60;

  // distance scale round(6371 * pi * 2^19), split in two 17-bit halves
  localparam logic [33:0]       DIST_MULT = 34'd10493669826;
  localparam logic [DIST_W-1:0] DIST_MAX  = 23'd5124000;

  // arctangent of 2^-i in binary angle units, 2^32 per turn
  function automatic logic [31:0] atan_bam(input int i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/great_circle_distance.sv]
// ---------------------------------------------------------------------------
// great_circle_distance: pipelined haversine distance
// distance from a configured reference point to each request position,
// using rotation cordic for sines and cosines, digit-per-stage square roots
// and a vectoring cordic for the central angle
// ---------------------------------------------------------------------------
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+-----------------
//  in      | in_position_latitude, in_position_longitude  | in_valid/in_stall
//  out     | out_distance                                 | out_valid/out_stall
//  cfg     | cfg_index, cfg_data                          | cfg_valid/cfg_ready
//
//  one request per cycle while the pipeline is not held; the depth is set by the
//  two cordic chains and the 31 square-root digit stages
//  the whole pipeline advances together and holds while a result waits
//  with out_stall high; empty slots carry a cleared valid bit
//  rst_n (synchronous) clears valid bits and the reference point
//
module great_circle_distance
  import gcd_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [LAT_W-1:0]      in_position_latitude,
  input  logic signed [LON_W-1:0]      in_position_longitude,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic        [DIST_W-1:0]     out_distance,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data
);

  // stage count limited to 1..32
  localparam int N     = (CORDIC_STAGES > 32) ? 32 :
                         ((CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES);
  localparam int LAT   = 2 * N + 43;
  localparam int XW    = 34;
  localparam int ZW    = 33;
  localparam int SQ_N  = 31;

  // pipeline control
  logic           adv;
  logic [LAT-1:0] vld_r, vld_nxt;

  assign adv       = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[LAT-1];
  assign cfg_ready = 1'b1;
  assign vld_nxt   = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // reference point registers
  logic signed [LAT_W-1:0] ref_lat_r;
  logic signed [LON_W-1:0] ref_lon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r <= '0;
      ref_lon_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REF_LAT: ref_lat_r <= cfg_data[LAT_W-1:0];
        REG_REF_LON: ref_lon_r <= cfg_data[LON_W-1:0];
        default: ;
      endcase
    end
  end

  // stage a: clamp and form magnitudes
  // lanes: 0 half dlat, 1 half dlon, 2 reference latitude, 3 position latitude
  logic signed [26:0] lat1_c, lat2_c, lon1_c, lon2_c, dlat, dlon;
  logic [24:0] a_mag_r [4];
  logic [24:0] a_mag_nxt [4];

  function automatic logic signed [26:0] clamp27(input logic signed [26:0] v,
                                                input logic signed [26:0] lim);
    logic signed [26:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

  function automatic logic [24:0] mag25(input logic signed [26:0] v);
    logic signed [26:0] m;
    m = (v < 0) ? -v : v;
    return m[24:0];
  endfunction

  always_comb begin
    lat1_c = clamp27(27'(ref_lat_r), LAT_LIMIT);
    lat2_c = clamp27(27'(in_position_latitude), LAT_LIMIT);
    lon1_c = clamp27(27'(ref_lon_r), LON_LIMIT);
    lon2_c = clamp27(27'(in_position_longitude), LON_LIMIT);
    dlat   = lat2_c - lat1_c;
    dlon   = lon2_c - lon1_c;
    a_mag_nxt[0] = mag25(dlat);
    a_mag_nxt[1] = mag25(dlon);
    a_mag_nxt[2] = mag25(lat1_c);
    a_mag_nxt[3] = mag25(lat2_c);
  end

  // stage b: quotient by 45 through reciprocal multiply, may be one low
  logic [19:0] b_q_r [4];
  logic [24:0] b_mag_r [4];
  logic [19:0] b_q_nxt [4];
  logic [50:0] b_prod [4];

  always_comb begin
    for (int ln = 0; ln < 4; ln++) begin
      b_prod[ln]  = 51'(a_mag_r[ln]) * 51'(RECIP_45);
      b_q_nxt[ln] = b_prod[ln][RECIP_SHIFT +: 20];
    end
  end

  // stage c: remainder and single correction step
  logic [19:0] c_q_r [4];
  logic [5:0]  c_rem_r [4];
  logic [19:0] c_q_nxt [4];
  logic [5:0]  c_rem_nxt [4];
  logic [25:0] c_diff [4];
  logic [6:0]  c_rem7 [4];

  always_comb begin
    for (int ln = 0; ln < 4; ln++) begin
      c_diff[ln] = 26'(b_mag_r[ln]) - 26'(b_q_r[ln]) * 26'(DegUnit);
      c_rem7[ln] = c_diff[ln][6:0];
      if (c_rem7[ln] >= 7'(DegUnit)) begin
        c_q_nxt[ln]   = b_q_r[ln] + 20'd1;
        c_rem_nxt[ln] = 6'(c_rem7[ln] - 7'(DegUnit));
      end else begin
        c_q_nxt[ln]   = b_q_r[ln];
        c_rem_nxt[ln] = c_rem7[ln][5:0];
      end
    end
  end

  // fraction tables: floor((r * 2^k + 45) / 90) for the remainder r
  logic [12:0] tbl_full [DegUnit];
  logic [12:0] tbl_half [DegUnit];

  for (genvar r = 0; r < DegUnit; r++) begin : g_tbl
    localparam logic [12:0] FullV = 13'((r * 16384 + DegUnit) / (2 * DegUnit));
    localparam logic [12:0] HalfV = 13'((r * 8192 + DegUnit) / (2 * DegUnit));
    assign tbl_full[r] = FullV;
    assign tbl_half[r] = HalfV;
  end

  // stage d and rotation cordic, index 0 holds the start vector
  logic signed [XW-1:0] rx_r [4][N+1];
  logic signed [XW-1:0] ry_r [4][N+1];
  logic signed [ZW-1:0] rz_r [4][N+1];
  logic signed [XW-1:0] rx_nxt [4][N+1];
  logic signed [XW-1:0] ry_nxt [4][N+1];
  logic signed [ZW-1:0] rz_nxt [4][N+1];
  logic [32:0] d_bam [4];
  logic [32:0] d_fold [4];
  logic signed [ZW-1:0] r_atan;

  always_comb begin
    r_atan = '0;
    for (int ln = 0; ln < 4; ln++) begin
      // binary angle, half lanes fold past a quarter turn
      if (ln < 2) begin
        d_bam[ln] = {1'b0, c_q_r[ln], 12'd0} + 33'(tbl_half[c_rem_r[ln]]);
        d_fold[ln] = (d_bam[ln] > (33'd1 << 30)) ? (33'd1 << 31) - d_bam[ln]
                                                  : d_bam[ln];
      end else begin
        d_bam[ln]  = {c_q_r[ln], 13'd0} + 33'(tbl_full[c_rem_r[ln]]);
        d_fold[ln] = d_bam[ln];
      end
      rx_nxt[ln][0] = GAIN_Q30;
      ry_nxt[ln][0] = '0;
      rz_nxt[ln][0] = $signed(d_fold[ln]);
      // one micro-rotation per stage
      for (int i = 1; i <= N; i++) begin
        r_atan = $signed({1'b0, atan_bam(i - 1)});
        if (rz_r[ln][i-1] >= 0) begin
          rx_nxt[ln][i] = rx_r[ln][i-1] - (ry_r[ln][i-1] >>> (i - 1));
          ry_nxt[ln][i] = ry_r[ln][i-1] + (rx_r[ln][i-1] >>> (i - 1));
          rz_nxt[ln][i] = rz_r[ln][i-1] - r_atan;
        end else begin
          rx_nxt[ln][i] = rx_r[ln][i-1] + (ry_r[ln][i-1] >>> (i - 1));
          ry_nxt[ln][i] = ry_r[ln][i-1] - (rx_r[ln][i-1] >>> (i - 1));
          rz_nxt[ln][i] = rz_r[ln][i-1] + r_atan;
        end
      end
    end
  end

  // stage e: clamp sines and cosines to [0, 1]
  q30_t e_trig_r [4];
  q30_t e_trig_nxt [4];
  logic signed [XW-1:0] e_val [4];

  always_comb begin
    for (int ln = 0; ln < 4; ln++) begin
      e_val[ln] = (ln < 2) ? ry_r[ln][N] : rx_r[ln][N];
      if (e_val[ln] < 0) e_trig_nxt[ln] = '0;
      else if (e_val[ln] > (XW'(1) <<< 30)) e_trig_nxt[ln] = q30_t'(1 << 30);
      else e_trig_nxt[ln] = e_val[ln][30:0];
    end
  end

  // products for a = sin^2(dlat/2) + cos*cos*sin^2(dlon/2)
  logic [61:0] m1_sq_r, m2_sq_r, m3_sq_r, m3_ts_r;
  q30_t        m1_cc_r, m1_s2_r, m2_t_r, m2_s2_r;
  logic [61:0] m1_cc_full, m2_t_full;

  assign m1_cc_full = 62'(e_trig_r[2]) * 62'(e_trig_r[3]) + HALF_Q30;
  assign m2_t_full  = 62'(m1_cc_r) * 62'(m1_s2_r) + HALF_Q30;

  // square roots, one result bit per stage; lane 0 sqrt(a), lane 1 sqrt(1-a)
  logic [60:0] sv_r [2][SQ_N+1];
  logic [61:0] sr_r [2][SQ_N+1];
  logic [60:0] sv_nxt [2][SQ_N+1];
  logic [61:0] sr_nxt [2][SQ_N+1];
  logic [62:0] m4_sum, m4_a;
  logic [61:0] sq_bit, sq_trial;

  always_comb begin
    m4_sum = 63'(m3_sq_r) + 63'(m3_ts_r);
    m4_a   = (m4_sum > ONE_Q60) ? ONE_Q60 : m4_sum;
    sv_nxt[0][0] = m4_a[60:0];
    sv_nxt[1][0] = 61'(ONE_Q60 - m4_a);
    sr_nxt[0][0] = '0;
    sr_nxt[1][0] = '0;
    sq_bit   = '0;
    sq_trial = '0;
    for (int ln = 0; ln < 2; ln++) begin
      for (int j = 1; j <= SQ_N; j++) begin
        sq_bit   = 62'd1 << (62 - 2 * j);
        sq_trial = sr_r[ln][j-1] + sq_bit;
        if (62'(sv_r[ln][j-1]) >= sq_trial) begin
          sv_nxt[ln][j] = 61'(62'(sv_r[ln][j-1]) - sq_trial);
          sr_nxt[ln][j] = (sr_r[ln][j-1] >> 1) + sq_bit;
        end else begin
          sv_nxt[ln][j] = sv_r[ln][j-1];
          sr_nxt[ln][j] = sr_r[ln][j-1] >> 1;
        end
      end
    end
  end

  // vectoring cordic on (sqrt(1-a), sqrt(a)), index 0 holds the start vector
  logic signed [XW-1:0] vx_r [N+1];
  logic signed [XW-1:0] vy_r [N+1];
  logic signed [ZW-1:0] vz_r [N+1];
  logic signed [XW-1:0] vx_nxt [N+1];
  logic signed [XW-1:0] vy_nxt [N+1];
  logic signed [ZW-1:0] vz_nxt [N+1];
  logic signed [ZW-1:0] v_atan;

  always_comb begin
    vx_nxt[0] = $signed({3'b000, sr_r[1][SQ_N][30:0]});
    vy_nxt[0] = $signed({3'b000, sr_r[0][SQ_N][30:0]});
    vz_nxt[0] = '0;
    v_atan    = '0;
    for (int i = 1; i <= N; i++) begin
      v_atan = $signed({1'b0, atan_bam(i - 1)});
      if (vy_r[i-1] >= 0) begin
        vx_nxt[i] = vx_r[i-1] + (vy_r[i-1] >>> (i - 1));
        vy_nxt[i] = vy_r[i-1] - (vx_r[i-1] >>> (i - 1));
        vz_nxt[i] = vz_r[i-1] + v_atan;
      end else begin
        vx_nxt[i] = vx_r[i-1] - (vy_r[i-1] >>> (i - 1));
        vy_nxt[i] = vy_r[i-1] + (vx_r[i-1] >>> (i - 1));
        vz_nxt[i] = vz_r[i-1] - v_atan;
      end
    end
  end

  // angle to distance: two partial products, then sum, round and saturate
  // the scaled product is kept modulo 2^64
  logic [31:0] p1_z;
  logic [48:0] p1_lo_r, p1_hi_r;
  logic [63:0] p2_sum;
  logic [DIST_W-1:0] p2_d;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;

  assign p1_z = (vz_r[N] < 0) ? 32'd0 : vz_r[N][31:0];

  always_comb begin
    p2_sum = 64'({p1_hi_r, 17'd0}) + 64'(p1_lo_r) + (64'd1 << 40);
    p2_d   = p2_sum[63:41];
    out_dist_nxt = (p2_d > DIST_MAX) ? DIST_MAX : p2_d;
  end

  assign out_distance = out_dist_r;

  // datapath registers, advance with the pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      a_mag_r   <= a_mag_nxt;
      b_q_r     <= b_q_nxt;
      b_mag_r   <= a_mag_r;
      c_q_r     <= c_q_nxt;
      c_rem_r   <= c_rem_nxt;
      rx_r      <= rx_nxt;
      ry_r      <= ry_nxt;
      rz_r      <= rz_nxt;
      e_trig_r  <= e_trig_nxt;
      m1_sq_r   <= 62'(e_trig_r[0]) * 62'(e_trig_r[0]);
      m1_cc_r   <= m1_cc_full[60:30];
      m1_s2_r   <= e_trig_r[1];
      m2_sq_r   <= m1_sq_r;
      m2_t_r    <= m2_t_full[60:30];
      m2_s2_r   <= m1_s2_r;
      m3_sq_r   <= m2_sq_r;
      m3_ts_r   <= 62'(m2_t_r) * 62'(m2_s2_r);
      sv_r      <= sv_nxt;
      sr_r      <= sr_nxt;
      vx_r      <= vx_nxt;
      vy_r      <= vy_nxt;
      vz_r      <= vz_nxt;
      p1_lo_r   <= 49'(p1_z) * 49'(DIST_MULT[16:0]);
      p1_hi_r   <= 49'(p1_z) * 49'(DIST_MULT[33:17]);
      out_dist_r <= out_dist_nxt;
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: great-circle distance block
// drives position requests against several reference points, predicts the
// distances with an integer cordic/haversine model and checks every result
// ---------------------------------------------------------------------------
module testbench;
  import gcd_pkg::*;

  localparam int STAGES  = 24;
  localparam int LATENCY = 2 * STAGES + 43;
  localparam int N_RAND  = 245;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam longint LAT_MAX_DEG = 5898240;
  localparam longint LON_MAX_DEG = 11796480;
  localparam longint TURN        = 23592960;
  localparam longint GAIN        = 652032874;
  localparam longint ONE30       = 64'd1 << 30;
  localparam longint unsigned ONE60 = 64'd1 << 60;
  localparam longint unsigned SCALE = 64'd10493669826;
  localparam longint unsigned SAT   = 64'd5124000;

  localparam longint ARCTAN [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [LAT_W-1:0]      in_position_latitude = '0;
  logic signed [LON_W-1:0]      in_position_longitude = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic        [DIST_W-1:0]     out_distance;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic        [CFG_IDX_W-1:0]  cfg_index = '0;
  logic        [CFG_DATA_W-1:0] cfg_data = '0;

  great_circle_distance #(.CORDIC_STAGES(STAGES)) u_dut (.*);

  always #2 clk = ~clk;

  // reference point as the block should hold it
  logic [LAT_W-1:0] ref_lat_reg = '0;
  logic [LON_W-1:0] ref_lon_reg = '0;

  logic [DIST_W-1:0] pending_distances [$];
  int                errors = 0;
  bit                calm = 1'b0;

  typedef struct {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    bit                      known;
    logic [DIST_W-1:0]       distance;
  } request_row_t;

  // ------------------------------------------------------------------ model
  function automatic int stage_limit();
    return STAGES > 32 ? 32 : (STAGES < 1 ? 1 : STAGES);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // rotation cordic, q30 cos and sin of a binary angle in [0, quarter turn]
  function automatic void cordic_sincos(input longint angle, output longint c,
                                        output longint s);
    longint x, y, z, dx, dy;
    x = GAIN;
    y = 0;
    z = angle;
    for (int i = 0; i < stage_limit(); i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    c = clip(x, 0, ONE30);
    s = clip(y, 0, ONE30);
  endfunction

  // vectoring cordic, angle of (x, y)
  function automatic longint cordic_atan(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < stage_limit(); i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ARCTAN[i];
      end else begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint lat_cosine(longint lat);
    longint unsigned m, bam;
    longint c, s;
    m = lat < 0 ? -lat : lat;
    bam = ((m << 32) + TURN / 2) / TURN;
    cordic_sincos(longint'(bam), c, s);
    return c;
  endfunction

  function automatic longint half_sine(longint delta);
    longint unsigned m, bam;
    longint c, s;
    m = delta < 0 ? -delta : delta;
    bam = ((m << 31) + TURN / 2) / TURN;
    if (bam > (64'd1 << 30)) bam = (64'd1 << 31) - bam;
    cordic_sincos(longint'(bam), c, s);
    return s;
  endfunction

  function automatic logic [DIST_W-1:0] haversine_km256(
      logic [LAT_W-1:0] rlat, logic [LON_W-1:0] rlon,
      logic [LAT_W-1:0] plat, logic [LON_W-1:0] plon);
    longint lat1, lon1, lat2, lon2, z;
    longint unsigned s1, s2, c1, c2, cc, t, a, d;
    lat1 = clip(longint'(signed'(rlat)), -LAT_MAX_DEG, LAT_MAX_DEG);
    lon1 = clip(longint'(signed'(rlon)), -LON_MAX_DEG, LON_MAX_DEG);
    lat2 = clip(longint'(signed'(plat)), -LAT_MAX_DEG, LAT_MAX_DEG);
    lon2 = clip(longint'(signed'(plon)), -LON_MAX_DEG, LON_MAX_DEG);
    s1 = half_sine(lat2 - lat1);
    s2 = half_sine(lon2 - lon1);
    c1 = lat_cosine(lat1);
    c2 = lat_cosine(lat2);
    cc = (c1 * c2 + (64'd1 << 29)) >> 30;
    t  = (cc * s2 + (64'd1 << 29)) >> 30;
    a  = s1 * s1 + t * s2;
    if (a > ONE60) a = ONE60;
    z = cordic_atan(longint'(floor_sqrt(ONE60 - a)), longint'(floor_sqrt(a)));
    if (z < 0) z = 0;
    d = (longint'(z) * SCALE + (64'd1 << 40)) >> 41;
    if (d > SAT) d = SAT;
    return d[DIST_W-1:0];
  endfunction

  // ------------------------------------------------------------ register io
  // leaves cfg_valid high, the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_REF_LAT) ref_lat_reg = val[LAT_W-1:0];
    else if (idx == REG_REF_LON) ref_lon_reg = val;
  endtask

  task automatic wait_drained();
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // one request, optionally followed by an idle burst
  task automatic send_position(logic [LAT_W-1:0] lat, logic [LON_W-1:0] lon,
                               bit known, logic [DIST_W-1:0] distance);
    int gap;
    in_valid              <= 1'b1;
    in_position_latitude  <= lat;
    in_position_longitude <= lon;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_distances.push_back(known ? distance
                                      : haversine_km256(ref_lat_reg, ref_lon_reg, lat, lon));
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random position, biased toward interesting geometry
  task automatic random_position(output logic [LAT_W-1:0] lat,
                                 output logic [LON_W-1:0] lon);
    longint rl, rn;
    rl = clip(longint'(signed'(ref_lat_reg)), -LAT_MAX_DEG, LAT_MAX_DEG);
    rn = clip(longint'(signed'(ref_lon_reg)), -LON_MAX_DEG, LON_MAX_DEG);
    case ($urandom_range(0, 9))
      0, 1: begin
        lat = LAT_W'($urandom);
        lon = LON_W'($urandom);
      end
      2, 3, 4, 5: begin
        lat = LAT_W'(longint'($urandom_range(0, 2 * LAT_MAX_DEG)) - LAT_MAX_DEG);
        lon = LON_W'(longint'($urandom_range(0, 2 * LON_MAX_DEG)) - LON_MAX_DEG);
      end
      6, 7: begin
        lat = LAT_W'(rl + longint'($urandom_range(0, 2000)) - 1000);
        lon = LON_W'(rn + longint'($urandom_range(0, 2000)) - 1000);
      end
      8: begin
        lat = LAT_W'(-rl + longint'($urandom_range(0, 200)) - 100);
        lon = LON_W'((rn > 0 ? rn - 2 * LON_MAX_DEG / 2 : rn + LON_MAX_DEG)
              + longint'($urandom_range(0, 200)) - 100);
      end
      default: begin
        lat = $urandom_range(0, 1) ? LAT_W'(LAT_MAX_DEG) : LAT_W'(-LAT_MAX_DEG);
        lon = $urandom_range(0, 1) ? LON_W'(LON_MAX_DEG) : LON_W'(-LON_MAX_DEG);
      end
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus
  initial begin
    request_row_t directed [$];
    logic [LAT_W-1:0] plat;
    logic [LON_W-1:0] plon;
    logic [LAT_W-1:0] ref_lats [6];
    logic [LON_W-1:0] ref_lons [6];

    directed = '{
      '{24'sd0, 25'sd0, 1'b1, 23'd0},
      '{24'sd5898240, 25'sd0, 1'b0, 23'd0},
      '{-24'sd5898240, 25'sd0, 1'b0, 23'd0},
      '{24'sd0, 25'sd11796480, 1'b0, 23'd0},
      '{24'sd0, -25'sd11796480, 1'b0, 23'd0},
      '{24'sd8388607, 25'sd16777215, 1'b0, 23'd0},
      '{24'sh800000, 25'sh1000000, 1'b0, 23'd0},
      '{24'sd5898241, -25'sd11796481, 1'b0, 23'd0},
      '{24'sd1, 25'sd1, 1'b0, 23'd0},
      '{-24'sd1, -25'sd1, 1'b0, 23'd0},
      '{24'sd0, 25'sd5898240, 1'b0, 23'd0},
      '{24'sd2949120, -25'sd8847360, 1'b0, 23'd0},
      '{24'sd5898240, 25'sd11796480, 1'b0, 23'd0},
      '{-24'sd5898240, -25'sd11796480, 1'b0, 23'd0},
      '{24'sd65536, 25'sd65536, 1'b0, 23'd0}
    };

    // reference settings: origin, extremes, out-of-range raw, random
    ref_lats = '{24'd0, 24'd5898240, -24'sd5898240, 24'h7FFFFF, 24'h800000, 24'd0};
    ref_lons = '{25'd0, 25'd11796480, -25'sd11796480, 25'h0FFFFFF, 25'h1000000, 25'd0};
    ref_lats[5] = LAT_W'(longint'($urandom_range(0, 2 * LAT_MAX_DEG)) - LAT_MAX_DEG);
    ref_lons[5] = LON_W'(longint'($urandom_range(0, 2 * LON_MAX_DEG)) - LON_MAX_DEG);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset reference is the origin
    foreach (directed[i])
      send_position(directed[i].lat, directed[i].lon, directed[i].known,
                    directed[i].distance);
    in_valid <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_reg(REG_REF_LAT, {1'($urandom_range(0, 1)), ref_lats[p]});
      write_reg(REG_REF_LON, ref_lons[p]);
      // undecoded indexes must leave the reference alone
      write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
      write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
      cfg_valid <= 1'b0;
      if (p == 5) calm = 1'b1;
      send_position(ref_lats[p], ref_lons[p], 1'b0, '0);
      for (int n = 0; n < N_RAND - 40 * (p == 5); n++) begin
        random_position(plat, plon);
        send_position(plat, plon, 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    fork
      begin
        while (pending_distances.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
      end
      begin
        repeat (200000) @(posedge clk);
        errors++;
      end
    join_any
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // ------------------------------------------------------ receiver stalling
  initial begin
    int run;
    forever begin
      if (calm || !rst_n) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 10);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (run) @(posedge clk);
      end
    end
  end

  // ------------------------------------------------------------ result check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_distances.size() == 0) begin
        errors++;
        $display("%0t: unexpected distance %0d", $time, out_distance);
      end else begin
        if (out_distance !== pending_distances[0]) begin
          errors++;
          $display("%0t: distance expected %0d actual %0d", $time,
                   pending_distances[0], out_distance);
        end
        void'(pending_distances.pop_front());
      end
    end
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
